// ===== rtl/core/task_priority_table_assert.svh =====
// Assertion macros shared by the task priority table RTL
`ifndef TASK_PRIORITY_TABLE_ASSERT_SVH
`define TASK_PRIORITY_TABLE_ASSERT_SVH

// Check on every clock edge outside reset
`define TPT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check on every clock edge, reset included
`define TPT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/core/tpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tpt_pkg;

   localparam int USER_W = 16;
   localparam int KEY_W  = 16;
   localparam int PRIO_W = 32;

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_EDIT   = 2'd1,
      ACT_REMOVE = 2'd2,
      ACT_EXEC   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // One table slot as stored in memory
   typedef struct packed {
      logic              valid;
      logic [USER_W-1:0] user;
      logic [KEY_W-1:0]  key;
      logic [PRIO_W-1:0] prio;
   } entry_type;

endpackage

`default_nettype wire

// ===== rtl/core/task_priority_table.sv =====
// Task priority table: add, edit, remove and execute-top on a table of tasks.
// Input channel req_*: one word per operation (action, user id, task id,
// priority), accepted when req_valid is high and req_stall is low.
// Result channel rsp_*: exactly one word per operation (status, top user),
// taken when rsp_valid is high and rsp_stall is low.
// Every operation sweeps the whole table through the single read port of the
// entry memory, one slot per cycle, then writes back at most one slot. The
// next word is accepted the cycle after the result is loaded, so the block
// takes no new operation before the last one has its result loaded.
// The default CAPACITY is 64.
// Reset clears the table by a pass that writes every slot empty, one slot a
// cycle; req_stall stays high until that pass ends.
// While rsp_stall holds a result, a new word may still be accepted and its
// sweep runs; its write-back and its result wait until the output register
// frees up.
`timescale 1ns / 1ps
`default_nettype none

module task_priority_table #(
   parameter int CAPACITY = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [15:0] req_user_id,
   input  wire logic [15:0] req_task_id,
   input  wire logic [31:0] req_priority_req,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [1:0]  rsp_status,
   output      logic [15:0] rsp_top_user
);
   import tpt_pkg::*;

   `include "task_priority_table_assert.svh"

   localparam int AW = $clog2(CAPACITY);
   localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_DONE
   } state_type;

   state_type         state_ff;
   logic [AW-1:0]     idx_ff;
   logic              rd_pend_ff;
   logic [AW-1:0]     rd_idx_ff;

   action_type        act_ff;
   logic [USER_W-1:0] user_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [PRIO_W-1:0] prio_ff;

   logic              match_hit_ff;
   logic [AW-1:0]     match_slot_ff;
   logic [USER_W-1:0] match_user_ff;
   logic              free_hit_ff;
   logic [AW-1:0]     free_slot_ff;
   logic              best_hit_ff;
   logic [AW-1:0]     best_slot_ff;
   logic [PRIO_W-1:0] best_prio_ff;
   logic [KEY_W-1:0]  best_key_ff;
   logic [USER_W-1:0] best_user_ff;

   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic [USER_W-1:0] rsp_user_ff;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   entry_type         wr_data;
   entry_type         rd_data;
   logic              out_free;
   logic              rsp_load;
   status_type        fin_status;
   logic [USER_W-1:0] fin_user;
   logic              is_match;
   logic              is_better;

   tpt_ram #(
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign req_stall    = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_top_user = rsp_user_ff;
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_load     = (state_ff == S_DONE) && out_free;

   // compare the slot returned by the memory against the request
   assign is_match  = rd_data.valid && (rd_data.key == key_ff);
   assign is_better = rd_data.valid &&
                      (!best_hit_ff || (rd_data.prio > best_prio_ff) ||
                       ((rd_data.prio == best_prio_ff) && (rd_data.key > best_key_ff)));

   // pick the clear-pass write, or the write-back and the result of the finished sweep
   always_comb begin
      wr_en      = 1'b0;
      wr_addr    = idx_ff;
      wr_data    = '0;
      fin_status = ST_OK;
      fin_user   = '0;
      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
         end
         S_DONE: begin
            case (act_ff)
               ACT_ADD: begin
                  wr_data.valid = 1'b1;
                  wr_data.user  = user_ff;
                  wr_data.key   = key_ff;
                  wr_data.prio  = prio_ff;
                  if (match_hit_ff) begin
                     wr_en   = out_free;
                     wr_addr = match_slot_ff;
                  end else if (free_hit_ff) begin
                     wr_en   = out_free;
                     wr_addr = free_slot_ff;
                  end else begin
                     fin_status = ST_FULL;
                  end
               end
               ACT_EDIT: begin
                  wr_data.valid = 1'b1;
                  wr_data.user  = match_user_ff;
                  wr_data.key   = key_ff;
                  wr_data.prio  = prio_ff;
                  wr_addr       = match_slot_ff;
                  wr_en         = out_free && match_hit_ff;
                  if (!match_hit_ff) begin
                     fin_status = ST_NOT_FOUND;
                  end
               end
               ACT_REMOVE: begin
                  wr_addr = match_slot_ff;
                  wr_en   = out_free && match_hit_ff;
                  if (!match_hit_ff) begin
                     fin_status = ST_NOT_FOUND;
                  end
               end
               ACT_EXEC: begin
                  wr_addr = best_slot_ff;
                  wr_en   = out_free && best_hit_ff;
                  if (best_hit_ff) begin
                     fin_user = best_user_ff;
                  end else begin
                     fin_status = ST_EMPTY;
                  end
               end
               default: begin
                  fin_status = ST_OK;
               end
            endcase
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // sequence clear pass, sweep and write-back; hold the result word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         idx_ff        <= '0;
         rd_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         match_hit_ff  <= 1'b0;
         free_hit_ff   <= 1'b0;
         best_hit_ff   <= 1'b0;
      end else begin
         rd_pend_ff <= (state_ff == S_SCAN);
         rd_idx_ff  <= idx_ff;

         // load a new result word, or drop the one just taken
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_CLEAR: begin
               if (idx_ff == LAST_IDX) begin
                  idx_ff   <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  idx_ff <= idx_ff + AW'(1);
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  act_ff       <= action_type'(req_action);
                  user_ff      <= req_user_id;
                  key_ff       <= req_task_id;
                  prio_ff      <= req_priority_req;
                  match_hit_ff <= 1'b0;
                  free_hit_ff  <= 1'b0;
                  best_hit_ff  <= 1'b0;
                  idx_ff       <= '0;
                  state_ff     <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (idx_ff == LAST_IDX) begin
                  idx_ff   <= '0;
                  state_ff <= S_DRAIN;
               end else begin
                  idx_ff <= idx_ff + AW'(1);
               end
            end
            S_DRAIN: begin
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_status_ff <= fin_status;
                  rsp_user_ff   <= fin_user;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         // fold the returned slot into the sweep results
         if (rd_pend_ff) begin
            if (is_match) begin
               match_hit_ff  <= 1'b1;
               match_slot_ff <= rd_idx_ff;
               match_user_ff <= rd_data.user;
            end
            if (!rd_data.valid && !free_hit_ff) begin
               free_hit_ff  <= 1'b1;
               free_slot_ff <= rd_idx_ff;
            end
            if (is_better) begin
               best_hit_ff  <= 1'b1;
               best_slot_ff <= rd_idx_ff;
               best_prio_ff <= rd_data.prio;
               best_key_ff  <= rd_data.key;
               best_user_ff <= rd_data.user;
            end
         end
      end
   end

   `TPT_ASSERT_ALWAYS(a_reset_clears, reset |=> (state_ff == S_CLEAR), "no clear after reset")
   `TPT_ASSERT(a_accept_scans, req_valid && !req_stall |=> state_ff == S_SCAN, "no sweep")
   `TPT_ASSERT(a_rsp_from_done, $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE), "early result")
   `TPT_ASSERT(a_write_phase, wr_en |-> (state_ff == S_CLEAR || state_ff == S_DONE), "bad write")
   `TPT_ASSERT(a_user_only_ok, rsp_valid_ff && |rsp_user_ff |-> rsp_status_ff == ST_OK, "stray user")

endmodule

`default_nettype wire

// ===== rtl/core/tpt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tpt_ram #(
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [AW-1:0]      wr_addr,
   input  wire tpt_pkg::entry_type wr_data,
   input  wire logic [AW-1:0]      rd_addr,
   output tpt_pkg::entry_type      rd_data
);
   import tpt_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // write one slot, read one slot with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
